[hdl/uva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uva_pkg
// Shared types and constants for the uncertain value ALU: operation and
// status codes, field widths and the control bundle carried down the pipe.
// ----------------------------------------------------------------------------
package uva_pkg;

  // default number of fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // field widths of the ports
  localparam int VALUE_W  = 32;
  localparam int ERROR_W  = 31;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // divisor magnitude width (|b +/- eb| stays below 2^32)
  localparam int DEN_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // control bundle that travels with each beat
  typedef struct packed {
    logic vld;
    op_e  op;
    logic b_zero;
    logic ea_zero;
    logic eb_zero;
    logic span;
    logic neg0;
    logic neg1;
    logic neg2;
  } ctl_t;

endpackage

[hdl/uva_div_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uva_div_lane
// Fully pipelined unsigned restoring divider: one quotient bit per stage,
// NUM_W stages, a new numerator/divisor pair accepted every cycle.
// ----------------------------------------------------------------------------
module uva_div_lane #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  // partial remainder and divisor carried between stages
  logic [DEN_W-1:0] rem_q [NUM_W-1];
  logic [DEN_W-1:0] den_q [NUM_W-1];
  // numerator bits shift out at the top while quotient bits shift in below
  logic [NUM_W-1:0] nq_q  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    // trial subtract of the divisor from the shifted remainder
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = ~diff[DEN_W];

    always_ff @(posedge clk_i) begin
      nq_q[k] <= {nq_in[NUM_W-2:0], take};
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

[hdl/uncertain_value_alu.sv]
`timescale 1ns / 1ps
// done_o marks each result beat; the default FRAC_BITS gives a Q16.16 format.
// Throughput: one beat per cycle; busy_o stays low, start_i may be high every cycle.
// The depth is set by the three restoring divider lanes, 33 + FRAC_BITS stages each.
// Every operation takes the same path, so results leave in acceptance order.
// Reset clears all valid bits; the receiver cannot stall, results show for one cycle.
// ----------------------------------------------------------------------------
// uncertain_value_alu
// Pipelined add/sub/mul/div of signed fixed point values that carry an
// absolute error bound, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
module uncertain_value_alu
  import uva_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [OP_W-1:0]            operation_i,
  input  logic signed [VALUE_W-1:0]  a_value_i,
  input  logic [ERROR_W-1:0]         a_error_i,
  input  logic signed [VALUE_W-1:0]  b_value_i,
  input  logic [ERROR_W-1:0]         b_error_i,
  output logic                       done_o,
  output logic signed [VALUE_W-1:0]  result_value_o,
  output logic [ERROR_W-1:0]         result_error_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int NUM_W    = 33 + FRAC_BITS;
  localparam int CS_W     = 64 - FRAC_BITS;
  localparam int VAL_W    = (CS_W > NUM_W + 1) ? CS_W : NUM_W + 1;
  localparam int SIDE_DLY = NUM_W - 2;
  localparam int LAT_CHK  = NUM_W + 7;

  localparam logic signed [63:0]      HALF   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0]      LIM62  = 66'sd1 <<< 62;
  localparam logic signed [VAL_W-1:0] VMAX_X = VAL_W'(32'sh7fff_ffff);
  localparam logic signed [VAL_W-1:0] VMIN_X = VAL_W'(32'sh8000_0000);
  localparam logic [VAL_W-1:0]        EMAX_X = VAL_W'(31'h7fff_ffff);

  function automatic logic [32:0] abs33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [65:0] abs66(input logic signed [65:0] x);
    return x[65] ? 66'(-x) : 66'(x);
  endfunction

  // never holds off a beat
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  logic                      s1_vld_q;
  op_e                       s1_op_q;
  logic signed [VALUE_W-1:0] s1_a_q, s1_b_q;
  logic [ERROR_W-1:0]        s1_ea_q, s1_eb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= op_e'(operation_i);
    s1_a_q  <= a_value_i;
    s1_ea_q <= a_error_i;
    s1_b_q  <= b_value_i;
    s1_eb_q <= b_error_i;
  end

  // --------------------------------------------------------------------------
  // stage 2: products, sums and divisor interval
  // --------------------------------------------------------------------------
  logic signed [32:0] a_x, b_x, ea_x, eb_x;
  logic signed [32:0] s2_hi_d, s2_lo_d;
  ctl_t               s2_ctl_d, s2_ctl_q;
  logic signed [63:0] s2_ab_q, s2_aeb_q, s2_eab_q;
  logic [61:0]        s2_eaeb_q;
  logic signed [32:0] s2_sval_q, s2_hi_q, s2_lo_q, s2_apm_q, s2_amm_q, s2_a_q, s2_b_q;
  logic [31:0]        s2_serr_q;
  logic [ERROR_W-1:0] s2_ea_q;

  assign a_x     = {s1_a_q[31], s1_a_q};
  assign b_x     = {s1_b_q[31], s1_b_q};
  assign ea_x    = {2'b00, s1_ea_q};
  assign eb_x    = {2'b00, s1_eb_q};
  assign s2_hi_d = b_x + eb_x;
  assign s2_lo_d = b_x - eb_x;

  always_comb begin
    s2_ctl_d         = '0;
    s2_ctl_d.vld     = s1_vld_q;
    s2_ctl_d.op      = s1_op_q;
    s2_ctl_d.b_zero  = (s1_b_q == '0);
    s2_ctl_d.ea_zero = (s1_ea_q == '0);
    s2_ctl_d.eb_zero = (s1_eb_q == '0);
    s2_ctl_d.span    = (s1_eb_q != '0) && (s2_lo_d <= 0) && (s2_hi_d >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q <= s2_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ab_q   <= s1_a_q * s1_b_q;
    s2_aeb_q  <= a_x * eb_x;
    s2_eab_q  <= ea_x * b_x;
    s2_eaeb_q <= s1_ea_q * s1_eb_q;
    s2_sval_q <= (s1_op_q == OP_SUB) ? a_x - b_x : a_x + b_x;
    s2_serr_q <= {1'b0, s1_ea_q} + {1'b0, s1_eb_q};
    s2_hi_q   <= s2_hi_d;
    s2_lo_q   <= s2_lo_d;
    s2_apm_q  <= a_x + ea_x;
    s2_amm_q  <= a_x - ea_x;
    s2_a_q    <= a_x;
    s2_b_q    <= b_x;
    s2_ea_q   <= s1_ea_q;
  end

  // --------------------------------------------------------------------------
  // stage 3: divider operands, product rounding, cross term sum
  // --------------------------------------------------------------------------
  logic               ceil_mode;
  logic signed [32:0] x1, y1, x2, y2;
  logic [31:0]        den0_d, den1_d, den2_d;
  logic [31:0]        mag_a, mag_x1, mag_x2;
  logic [NUM_W-1:0]   num0_d, num1_d, num2_d;
  logic signed [63:0] pround;
  ctl_t               s3_ctl_d, s3_ctl_q;
  logic [NUM_W-1:0]   s3_num0_q, s3_num1_q, s3_num2_q;
  logic [DEN_W-1:0]   s3_den0_q, s3_den1_q, s3_den2_q;
  logic signed [CS_W-1:0] s3_pval_q;
  logic signed [64:0] s3_s_q;
  logic [61:0]        s3_t_q;
  logic [63:0]        s3_x_q;
  logic signed [32:0] s3_sval_q;
  logic [31:0]        s3_serr_q;

  // corner selection: only eb set, or both set; only ea set uses a ceiling divide
  assign ceil_mode = !s2_ctl_q.ea_zero && s2_ctl_q.eb_zero;
  assign x1 = s2_ctl_q.ea_zero ? s2_a_q  : s2_apm_q;
  assign y1 = s2_ctl_q.ea_zero ? s2_hi_q : s2_lo_q;
  assign x2 = s2_ctl_q.ea_zero ? s2_a_q  : s2_amm_q;
  assign y2 = s2_ctl_q.ea_zero ? s2_lo_q : s2_hi_q;

  assign mag_a  = 32'(abs33(s2_a_q));
  assign mag_x1 = 32'(abs33(x1));
  assign mag_x2 = 32'(abs33(x2));
  assign den0_d = 32'(abs33(s2_b_q));
  assign den1_d = 32'(abs33(y1));
  assign den2_d = 32'(abs33(y2));

  // round to nearest by adding half the divisor (ceil_mode: num1 adds the divisor minus one)
  assign num0_d = {1'b0, mag_a, {FRAC_BITS{1'b0}}} + NUM_W'(den0_d >> 1);
  assign num1_d = ceil_mode
                ? {2'b00, s2_ea_q, {FRAC_BITS{1'b0}}} + NUM_W'(den1_d) - NUM_W'(1)
                : {1'b0, mag_x1, {FRAC_BITS{1'b0}}} + NUM_W'(den1_d >> 1);
  assign num2_d = {1'b0, mag_x2, {FRAC_BITS{1'b0}}} + NUM_W'(den2_d >> 1);

  assign pround = s2_ab_q + HALF;

  always_comb begin
    s3_ctl_d      = s2_ctl_q;
    s3_ctl_d.neg0 = s2_a_q[32] ^ s2_b_q[32];
    s3_ctl_d.neg1 = !ceil_mode && (x1[32] ^ y1[32]);
    s3_ctl_d.neg2 = x2[32] ^ y2[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
    end else begin
      s3_ctl_q <= s3_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_num0_q <= num0_d;
    s3_num1_q <= num1_d;
    s3_num2_q <= num2_d;
    s3_den0_q <= den0_d;
    s3_den1_q <= den1_d;
    s3_den2_q <= den2_d;
    s3_pval_q <= pround[63:FRAC_BITS];
    s3_s_q    <= $signed({s2_aeb_q[63], s2_aeb_q}) + $signed({s2_eab_q[63], s2_eab_q});
    s3_t_q    <= s2_eaeb_q;
    s3_x_q    <= s2_ctl_q.ea_zero ? abs64(s2_aeb_q) : abs64(s2_eab_q);
    s3_sval_q <= s2_sval_q;
    s3_serr_q <= s2_serr_q;
  end

  // --------------------------------------------------------------------------
  // divider lanes: nominal quotient and two corners
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] quo0, quo1, quo2;

  uva_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div0 (
    .clk_i(clk_i), .num_i(s3_num0_q), .den_i(s3_den0_q), .quo_o(quo0)
  );

  uva_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div1 (
    .clk_i(clk_i), .num_i(s3_num1_q), .den_i(s3_den1_q), .quo_o(quo1)
  );

  uva_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div2 (
    .clk_i(clk_i), .num_i(s3_num2_q), .den_i(s3_den2_q), .quo_o(quo2)
  );

  // --------------------------------------------------------------------------
  // stage 4: corner deviations of the product, single-error ceiling
  // --------------------------------------------------------------------------
  logic signed [65:0] s66, ns66, t66;
  ctl_t               s4_ctl_q;
  logic signed [65:0] s4_d1_q, s4_d2_q;
  logic [CS_W-1:0]    s4_cs_q;
  logic signed [CS_W-1:0] s4_pval_q;
  logic signed [32:0] s4_sval_q;
  logic [31:0]        s4_serr_q;

  assign s66  = $signed({s3_s_q[64], s3_s_q});
  assign ns66 = -s66;
  assign t66  = $signed({4'b0000, s3_t_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctl_q <= '0;
    end else begin
      s4_ctl_q <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_d1_q   <= ((s66 < LIM62) ? s66 : LIM62) + t66;
    s4_d2_q   <= ((ns66 < LIM62) ? ns66 : LIM62) + t66;
    s4_cs_q   <= CS_W'(s3_x_q >> FRAC_BITS) + CS_W'(|s3_x_q[FRAC_BITS-1:0]);
    s4_pval_q <= s3_pval_q;
    s4_sval_q <= s3_sval_q;
    s4_serr_q <= s3_serr_q;
  end

  // --------------------------------------------------------------------------
  // stage 5: deviation magnitudes
  // --------------------------------------------------------------------------
  ctl_t               s5_ctl_q;
  logic [63:0]        s5_m1_q, s5_m2_q;
  logic [CS_W-1:0]    s5_cs_q;
  logic signed [CS_W-1:0] s5_pval_q;
  logic signed [32:0] s5_sval_q;
  logic [31:0]        s5_serr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_ctl_q <= '0;
    end else begin
      s5_ctl_q <= s4_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_m1_q   <= 64'(abs66(s4_d1_q));
    s5_m2_q   <= 64'(abs66(s4_d2_q));
    s5_cs_q   <= s4_cs_q;
    s5_pval_q <= s4_pval_q;
    s5_sval_q <= s4_sval_q;
    s5_serr_q <= s4_serr_q;
  end

  // --------------------------------------------------------------------------
  // stage 6: add/sub/mul results, then delay to meet the divider lanes
  // --------------------------------------------------------------------------
  logic [63:0]             mmax;
  logic [CS_W-1:0]         mceil, merr;
  logic signed [VAL_W-1:0] side_val;
  logic [VAL_W-1:0]        side_err;
  ctl_t                    dly_ctl_q [SIDE_DLY];
  logic signed [VAL_W-1:0] dly_val_q [SIDE_DLY];
  logic [VAL_W-1:0]        dly_err_q [SIDE_DLY];

  assign mmax  = (s5_m1_q > s5_m2_q) ? s5_m1_q : s5_m2_q;
  assign mceil = CS_W'(mmax >> FRAC_BITS) + CS_W'(|mmax[FRAC_BITS-1:0]);

  always_comb begin
    if (s5_ctl_q.ea_zero && s5_ctl_q.eb_zero) begin
      merr = '0;
    end else if (s5_ctl_q.ea_zero || s5_ctl_q.eb_zero) begin
      merr = s5_cs_q;
    end else begin
      merr = mceil;
    end
  end

  always_comb begin
    case (s5_ctl_q.op)
      OP_ADD, OP_SUB: begin
        side_val = VAL_W'(s5_sval_q);
        side_err = VAL_W'(s5_serr_q);
      end
      OP_MUL: begin
        side_val = VAL_W'(s5_pval_q);
        side_err = VAL_W'(merr);
      end
      default: begin
        side_val = '0;
        side_err = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIDE_DLY; i++) begin
        dly_ctl_q[i] <= '0;
      end
    end else begin
      dly_ctl_q[0] <= s5_ctl_q;
      for (int i = 1; i < SIDE_DLY; i++) begin
        dly_ctl_q[i] <= dly_ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_val_q[0] <= side_val;
    dly_err_q[0] <= side_err;
    for (int i = 1; i < SIDE_DLY; i++) begin
      dly_val_q[i] <= dly_val_q[i-1];
      dly_err_q[i] <= dly_err_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // f0: apply quotient signs
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] u0, u1, u2;
  ctl_t                    f0_ctl_q;
  logic signed [VAL_W-1:0] f0_q0_q, f0_c1_q, f0_c2_q, f0_val_q;
  logic [VAL_W-1:0]        f0_err_q;

  assign u0 = VAL_W'(quo0);
  assign u1 = VAL_W'(quo1);
  assign u2 = VAL_W'(quo2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_ctl_q <= '0;
    end else begin
      f0_ctl_q <= dly_ctl_q[SIDE_DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    f0_q0_q  <= dly_ctl_q[SIDE_DLY-1].neg0 ? -u0 : u0;
    f0_c1_q  <= dly_ctl_q[SIDE_DLY-1].neg1 ? -u1 : u1;
    f0_c2_q  <= dly_ctl_q[SIDE_DLY-1].neg2 ? -u2 : u2;
    f0_val_q <= dly_val_q[SIDE_DLY-1];
    f0_err_q <= dly_err_q[SIDE_DLY-1];
  end

  // --------------------------------------------------------------------------
  // f1: corner minus nominal quotient
  // --------------------------------------------------------------------------
  ctl_t                    f1_ctl_q;
  logic signed [VAL_W:0]   f1_e1_q, f1_e2_q;
  logic signed [VAL_W-1:0] f1_q0_q, f1_c1_q, f1_val_q;
  logic [VAL_W-1:0]        f1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_ctl_q <= '0;
    end else begin
      f1_ctl_q <= f0_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_e1_q  <= $signed({f0_c1_q[VAL_W-1], f0_c1_q}) - $signed({f0_q0_q[VAL_W-1], f0_q0_q});
    f1_e2_q  <= $signed({f0_c2_q[VAL_W-1], f0_c2_q}) - $signed({f0_q0_q[VAL_W-1], f0_q0_q});
    f1_q0_q  <= f0_q0_q;
    f1_c1_q  <= f0_c1_q;
    f1_val_q <= f0_val_q;
    f1_err_q <= f0_err_q;
  end

  // --------------------------------------------------------------------------
  // f2: deviation magnitudes, value and plain error select
  // --------------------------------------------------------------------------
  logic                    f1_div;
  logic [VAL_W-1:0]        raw_err;
  ctl_t                    f2_ctl_q;
  logic [VAL_W-1:0]        f2_m1_q, f2_m2_q, f2_raw_q;
  logic signed [VAL_W-1:0] f2_val_q;

  assign f1_div = (f1_ctl_q.op == OP_DIV);

  always_comb begin
    if (!f1_div) begin
      raw_err = f1_err_q;
    end else if (!f1_ctl_q.eb_zero) begin
      raw_err = EMAX_X;
    end else if (f1_ctl_q.ea_zero) begin
      raw_err = '0;
    end else begin
      raw_err = $unsigned(f1_c1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_ctl_q <= '0;
    end else begin
      f2_ctl_q <= f1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f2_m1_q  <= f1_e1_q[VAL_W] ? VAL_W'(-f1_e1_q) : VAL_W'(f1_e1_q);
    f2_m2_q  <= f1_e2_q[VAL_W] ? VAL_W'(-f1_e2_q) : VAL_W'(f1_e2_q);
    f2_raw_q <= raw_err;
    f2_val_q <= f1_div ? f1_q0_q : f1_val_q;
  end

  // --------------------------------------------------------------------------
  // f3: error max, saturation and status into the output register
  // --------------------------------------------------------------------------
  logic                      f2_div, use_max, sat_hi, sat_lo, sat_e, sat_any;
  logic [VAL_W-1:0]          fin_err;
  logic                      done_q;
  logic signed [VALUE_W-1:0] res_val_d, res_val_q;
  logic [ERROR_W-1:0]        res_err_d, res_err_q;
  status_e                   res_st_d, res_st_q;

  assign f2_div  = (f2_ctl_q.op == OP_DIV);
  assign use_max = f2_div && !f2_ctl_q.span && !f2_ctl_q.eb_zero;
  assign fin_err = use_max ? ((f2_m1_q > f2_m2_q) ? f2_m1_q : f2_m2_q) : f2_raw_q;
  assign sat_hi  = f2_val_q > VMAX_X;
  assign sat_lo  = f2_val_q < VMIN_X;
  assign sat_e   = fin_err > EMAX_X;
  assign sat_any = sat_hi || sat_lo || sat_e || (f2_div && f2_ctl_q.span);

  always_comb begin
    if (f2_div && f2_ctl_q.b_zero) begin
      res_val_d = '0;
      res_err_d = '0;
      res_st_d  = ST_DIV_ZERO;
    end else begin
      if (sat_hi) begin
        res_val_d = 32'sh7fff_ffff;
      end else if (sat_lo) begin
        res_val_d = 32'sh8000_0000;
      end else begin
        res_val_d = f2_val_q[VALUE_W-1:0];
      end
      res_err_d = sat_e ? 31'h7fff_ffff : fin_err[ERROR_W-1:0];
      res_st_d  = sat_any ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= f2_ctl_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    res_st_q  <= res_st_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_val_q;
  assign result_error_o = res_err_q;
  assign status_o       = res_st_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // every result beat goes back to an accepted beat at the fixed depth
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT_CHK))
    else $error("result beat without a matching accepted beat");

  // divide-by-zero status only for a divide with a zero divisor
  a_divz_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DIV_ZERO) |->
      ($past(operation_i, LAT_CHK) == OP_DIV && $past(b_value_i, LAT_CHK) == '0))
    else $error("divide-by-zero status on a beat that had no zero divisor");

  // divide-by-zero gives zero value and zero error
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DIV_ZERO) |-> (result_value_o == '0 && result_error_o == '0))
    else $error("divide-by-zero result is not cleared");

  // side path stays aligned with the divider lanes
  a_lane_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_ctl_q.vld |-> ##(NUM_W) dly_ctl_q[SIDE_DLY-1].vld)
    else $error("side data lost alignment with the divider lanes");

endmodule
